/* rtl/core/i2cbb_pkg.sv */
// Shared types, command codes and phase constants of the two-wire bit-bang master.
package i2cbb_pkg;

  localparam int unsigned HalfPeriodCyclesDefault = 250;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // A byte command runs through eighteen phases, numbered 0 to 17.
  localparam int unsigned PhaseW        = 5;
  localparam logic [PhaseW-1:0] PH_ACK_HI = 5'd16;
  localparam logic [PhaseW-1:0] PH_LAST   = 5'd17;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] write_byte;
    logic       send_nack;
    logic [8:0] line_samples;
  } cmd_t;

  typedef struct packed {
    logic       clock_line;
    logic       data_line;
    logic       data_drive;
    logic       hold_phase;
    logic       last;
    logic [7:0] read_byte;
    logic       nack_seen;
  } phase_t;

  // Bus levels and bookkeeping for one phase, from the phase decoder.
  typedef struct packed {
    logic scl;
    logic sda;
    logic drive;
    logic hold;
    logic last;
    logic shift;
  } phase_ctl_t;

endpackage

/* rtl/core/i2cbb_cmd_if.sv */
// Command channel: valid/ready handshake carrying one bus command.
interface i2cbb_cmd_if import i2cbb_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/i2cbb_phase_if.sv */
// Phase channel: valid/ready handshake carrying one bus phase.
interface i2cbb_phase_if import i2cbb_pkg::*; ();
  logic   valid;
  logic   ready;
  phase_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/i2c_bitbang_master_engine.sv */
// Two-wire bus master sequencer: turns start, stop, write and read commands into bus phases.
// One command is taken at a time. Each command produces a run of phases on the phase channel
// (three for start, two for stop, eighteen for a byte write or read), and every held phase is
// followed by a half-period wait in the timer, set by HALF_PERIOD_CYCLES, before the next
// phase is issued; the sink can also stall the phase channel. The byte to send and the
// sampled SDA levels move through shift registers one bit per SCL period. A new command
// is taken as soon as the last phase of the previous one has been issued and, if that phase
// is held, its half period has elapsed, even while that phase awaits its transfer.
module i2c_bitbang_master_engine import i2cbb_pkg::*; #(
  parameter int unsigned HALF_PERIOD_CYCLES = HalfPeriodCyclesDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  i2cbb_cmd_if.sink     cmd_i,
  i2cbb_phase_if.source phase_o
);

  localparam int unsigned TimerW = $clog2(HALF_PERIOD_CYCLES + 1);
  localparam logic [TimerW-1:0] TimerLoad = TimerW'(HALF_PERIOD_CYCLES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [1:0]        op_q, op_d;
  logic              nack_q, nack_d;
  logic [7:0]        wsh_q, wsh_d;
  logic [7:0]        samp_q, samp_d;
  logic [7:0]        acc_q, acc_d;
  logic              out_valid_q, out_valid_d;
  phase_t            out_q, out_d;

  phase_ctl_t ctl;
  logic       cmd_take;
  logic       slot_free;
  logic       load;

  i2cbb_phase_dec u_phase_dec (
    .op_i    (op_q),
    .phase_i (phase_q),
    .wbit_i  (wsh_q[7]),
    .nack_i  (nack_q),
    .ctl_o   (ctl)
  );

  assign cmd_i.ready     = (state_q == ST_IDLE);
  assign cmd_take        = cmd_i.valid & cmd_i.ready;
  assign slot_free       = ~out_valid_q | phase_o.ready;
  assign load            = (state_q == ST_EMIT) & slot_free;
  assign phase_o.valid   = out_valid_q;
  assign phase_o.payload = out_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    timer_d     = timer_q;
    op_d        = op_q;
    nack_d      = nack_q;
    wsh_d       = wsh_q;
    samp_d      = samp_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q & ~phase_o.ready;
    out_d       = out_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_take) begin
          op_d    = cmd_i.payload.operation;
          nack_d  = cmd_i.payload.send_nack;
          wsh_d   = cmd_i.payload.write_byte;
          samp_d  = cmd_i.payload.line_samples[7:0];
          acc_d   = '0;
          phase_d = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_d          = 1'b1;
          out_d.clock_line     = ctl.scl;
          out_d.data_line      = ctl.drive ? ctl.sda : 1'b1;
          out_d.data_drive     = ctl.drive;
          out_d.hold_phase     = ctl.hold;
          out_d.last           = ctl.last;
          out_d.read_byte      = (ctl.last && op_q == OP_READ) ? acc_q : '0;
          out_d.nack_seen      = ctl.last && (op_q == OP_WRITE) && samp_q[0];
          // Bits advance once per SCL period, on the low half.
          if (ctl.shift && op_q == OP_WRITE) begin
            wsh_d = {wsh_q[6:0], 1'b0};
          end
          if (ctl.shift && op_q == OP_READ) begin
            acc_d  = {acc_q[6:0], samp_q[7]};
            samp_d = {samp_q[6:0], 1'b0};
          end
          phase_d = phase_q + PhaseW'(1);
          timer_d = TimerLoad;
          if (ctl.hold) begin
            state_d = ST_WAIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_WAIT: begin
        if (timer_q == '0) begin
          state_d = out_q.last ? ST_IDLE : ST_EMIT;
        end else begin
          timer_d = timer_q - TimerW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    nack_q <= nack_d;
    wsh_q  <= wsh_d;
    samp_q <= samp_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  a_take_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |=> (state_q == ST_EMIT))
    else $error("accepted command did not start a phase run");

  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (phase_q <= PH_LAST))
    else $error("phase index ran past the end of a run");

  a_unheld_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && ctl.last && !ctl.hold) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("unheld final phase did not end the run");

  a_no_load_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !phase_o.ready) |-> !load)
    else $error("phase register overwritten before its transfer");

endmodule

/* rtl/core/i2cbb_phase_dec.sv */
// Phase decoder: bus levels and control for one phase of a command's run.
module i2cbb_phase_dec import i2cbb_pkg::*; (
  input  logic [1:0]        op_i,
  input  logic [PhaseW-1:0] phase_i,
  input  logic              wbit_i,
  input  logic              nack_i,
  output phase_ctl_t        ctl_o
);

  logic in_byte;

  assign in_byte = (phase_i < PH_ACK_HI);

  always_comb begin
    ctl_o = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, hold: 1'b1, last: 1'b0, shift: 1'b0};
    case (op_i)
      OP_START: begin
        ctl_o.sda  = (phase_i == '0);
        ctl_o.scl  = (phase_i != 5'd2);
        ctl_o.hold = (phase_i != 5'd2);
        ctl_o.last = (phase_i == 5'd2);
      end
      OP_STOP: begin
        ctl_o.sda  = (phase_i != '0);
        ctl_o.last = (phase_i != '0);
      end
      OP_WRITE: begin
        ctl_o.scl   = ~phase_i[0];
        ctl_o.sda   = in_byte ? wbit_i : 1'b1;
        ctl_o.drive = in_byte;
        ctl_o.last  = (phase_i == PH_LAST);
        ctl_o.shift = in_byte & phase_i[0];
      end
      OP_READ: begin
        ctl_o.scl   = ~phase_i[0];
        ctl_o.sda   = in_byte ? 1'b1 : nack_i;
        ctl_o.drive = ~in_byte;
        ctl_o.last  = (phase_i == PH_LAST);
        ctl_o.shift = in_byte & phase_i[0];
      end
      default: begin
        ctl_o.last = 1'b1;
      end
    endcase
  end

endmodule

/* tb/tb_i2c_bitbang_master_engine.sv */
// Self-checking testbench for the two-wire bit-bang master sequencer.
module tb_i2c_bitbang_master_engine;
  import i2cbb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // A short half period keeps the run brief; the phase sequence does not depend on it.
  localparam int unsigned HALF_CYCLES = 6;
  localparam int unsigned SETTLE_CYCLES = 4 * (HALF_CYCLES + 1) + 40;

  logic clk = 1'b0;
  logic rst_n;

  i2cbb_cmd_if   cmd_if ();
  i2cbb_phase_if phase_if ();

  i2c_bitbang_master_engine #(
    .HALF_PERIOD_CYCLES(HALF_CYCLES)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .phase_o(phase_if)
  );

  phase_t      expected_phases[$];
  int unsigned error_count = 0;
  int unsigned cmds_sent = 0;
  bit          sender_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned sink_hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_phase(logic scl, logic sda, logic drive, logic hold,
                                     logic fin, logic [7:0] rbyte, logic nack);
    phase_t p;
    p.clock_line = scl;
    // A released line reads as the pulled-up level.
    p.data_line  = drive ? sda : 1'b1;
    p.data_drive = drive;
    p.hold_phase = hold;
    p.last       = fin;
    p.read_byte  = rbyte;
    p.nack_seen  = nack;
    expected_phases.push_back(p);
  endfunction

  function automatic void predict_bus_phases(cmd_t c);
    logic [7:0] shreg;
    logic [7:0] acc;
    case (c.operation)
      OP_START: begin
        push_phase(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        push_phase(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        push_phase(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0);
      end
      OP_STOP: begin
        push_phase(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        push_phase(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
      end
      OP_WRITE: begin
        shreg = c.write_byte;
        for (int i = 0; i < 8; i++) begin
          push_phase(1'b1, shreg[7], 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
          push_phase(1'b0, shreg[7], 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
          shreg = {shreg[6:0], 1'b0};
        end
        push_phase(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        push_phase(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, c.line_samples[0]);
      end
      OP_READ: begin
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
          acc = {acc[6:0], c.line_samples[7-i]};
          push_phase(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
          push_phase(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        end
        push_phase(1'b1, c.send_nack, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        push_phase(1'b0, c.send_nack, 1'b1, 1'b1, 1'b1, acc, 1'b0);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic cmd_t make_cmd(logic [1:0] op, logic [7:0] wbyte, logic nack,
                                    logic [8:0] samples);
    cmd_t c;
    c.operation    = op;
    c.write_byte   = wbyte;
    c.send_nack    = nack;
    c.line_samples = samples;
    return c;
  endfunction

  function automatic cmd_t random_cmd(logic [1:0] op);
    return make_cmd(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    9'($urandom_range(0, 511)));
  endfunction

  // Offers one command and returns at the edge where its transfer takes place.
  task automatic send_cmd(cmd_t c);
    int unsigned gap;
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= c;
    do @(posedge clk); while (!cmd_if.ready);
    predict_bus_phases(c);
    cmds_sent++;
  endtask

  task automatic wait_for_drain();
    cmd_if.valid <= 1'b0;
    wait (expected_phases.size() == 0);
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_cmd(make_cmd(OP_START, 8'h00, 1'b0, 9'h000));
    send_cmd(make_cmd(OP_WRITE, 8'h00, 1'b0, 9'h000));
    send_cmd(make_cmd(OP_WRITE, 8'hFF, 1'b1, 9'h1FF));
    // Acknowledge low with every ignored sample bit set.
    send_cmd(make_cmd(OP_WRITE, 8'hA5, 1'b1, 9'h1FE));
    send_cmd(make_cmd(OP_WRITE, 8'h5A, 1'b0, 9'h001));
    // Repeated start in the middle of a transaction.
    send_cmd(make_cmd(OP_START, 8'hFF, 1'b1, 9'h1FF));
    send_cmd(make_cmd(OP_READ, 8'hFF, 1'b0, 9'h000));
    send_cmd(make_cmd(OP_READ, 8'h00, 1'b1, 9'h1FF));
    send_cmd(make_cmd(OP_READ, 8'h3C, 1'b0, 9'h1A5));
    send_cmd(make_cmd(OP_READ, 8'hC3, 1'b1, 9'h05A));
    send_cmd(make_cmd(OP_READ, 8'h81, 1'b0, 9'h0FF));
    send_cmd(make_cmd(OP_STOP, 8'hFF, 1'b1, 9'h1FF));
    send_cmd(make_cmd(OP_STOP, 8'h00, 1'b0, 9'h000));
    send_cmd(make_cmd(OP_START, 8'h12, 1'b0, 9'h100));
    send_cmd(make_cmd(OP_STOP, 8'h34, 1'b1, 9'h0AA));
  endtask

  // Mostly well-formed transactions with random content, with some stray commands between.
  task automatic test_random_transactions(int unsigned target);
    cmd_t        c;
    int unsigned n_data;
    while (cmds_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        send_cmd(random_cmd(2'($urandom_range(0, 3))));
      end else begin
        send_cmd(random_cmd(OP_START));
        c = random_cmd(OP_WRITE);
        c.line_samples[0] = ($urandom_range(0, 7) == 0);
        send_cmd(c);
        n_data = $urandom_range(1, 4);
        for (int i = 0; i < n_data; i++) begin
          send_cmd(random_cmd($urandom_range(0, 1) ? OP_READ : OP_WRITE));
        end
        send_cmd(random_cmd(OP_STOP));
      end
    end
  endtask

  // The receiver holds off while commands keep coming, then the sender waits for the drain.
  task automatic test_backpressure();
    sink_hold_cycles = 400;
    for (int i = 0; i < 10; i++) begin
      send_cmd(random_cmd(2'($urandom_range(0, 3))));
    end
    wait_for_drain();
  endtask

  task automatic test_steady_stream(int unsigned n_cmds);
    sender_idle_on = 1'b0;
    sink_idle_on   = 1'b0;
    for (int i = 0; i < n_cmds; i++) begin
      send_cmd(random_cmd(2'($urandom_range(0, 3))));
    end
  endtask

  initial begin : phase_sink
    int unsigned stall;
    phase_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (sink_hold_cycles != 0) begin
        phase_if.ready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
        phase_if.ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 15);
        phase_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        phase_if.ready <= 1'b1;
      end else begin
        phase_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : phase_checker
    phase_t exp_phase;
    if (rst_n && phase_if.valid && phase_if.ready) begin
      if (expected_phases.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("%0t: unexpected phase transfer %p", $realtime, phase_if.payload);
        end
      end else begin
        exp_phase = expected_phases.pop_front();
        if (phase_if.payload !== exp_phase) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: phase mismatch scl %b/%b sda %b/%b drive %b/%b hold %b/%b",
                     $realtime, exp_phase.clock_line, phase_if.payload.clock_line,
                     exp_phase.data_line, phase_if.payload.data_line,
                     exp_phase.data_drive, phase_if.payload.data_drive,
                     exp_phase.hold_phase, phase_if.payload.hold_phase);
            $display("  last %b/%b read_byte %h/%h nack %b/%b (expected/actual)",
                     exp_phase.last, phase_if.payload.last,
                     exp_phase.read_byte, phase_if.payload.read_byte,
                     exp_phase.nack_seen, phase_if.payload.nack_seen);
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cmd_if.valid   <= 1'b0;
    cmd_if.payload <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_transactions(85);
    test_backpressure();
    test_steady_stream(40);

    cmd_if.valid <= 1'b0;
    wait (expected_phases.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_phases.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : run_limit
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
